### src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window maximum
// Holds the control structs that pass between the cell row, the front
// selector and the top level, the register port width and the group size.
// ----------------------------------------------------------------------------
package swm_pkg;

	// Width of the window_size configuration register.
	localparam int CFG_BITS = 7;

	// Lanes that the front selector examines per group in its first stage.
	localparam int GROUP_LANES = 8;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic shift;  // an item is accepted: every cell takes its neighbour's entry
		logic flush;  // the previous item ended an array: drop all live entries
	} swm_ctrl_t;

	// Item tag that travels alongside the state through the selector stages.
	typedef struct packed {
		logic valid;  // this item produces a result
		logic last;   // the result closes an array
	} swm_stage_t;

endpackage

### src/swm_sample_if.sv
// ----------------------------------------------------------------------------
// swm_sample_if: input sample channel
// Carries one signed sample and its end-of-array flag per item.
// ----------------------------------------------------------------------------
interface swm_sample_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

### src/swm_result_if.sv
// ----------------------------------------------------------------------------
// swm_result_if: result channel
// Carries one window maximum and its end-of-array flag per item.
// ----------------------------------------------------------------------------
interface swm_result_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;
	logic                          last_result;

	modport source (output valid, output window_max, output last_result, input ready);
	modport sink   (input valid, input window_max, input last_result, output ready);
endinterface

### src/swm_cfg_if.sv
// ----------------------------------------------------------------------------
// swm_cfg_if: configuration write channel
// Carries the write data of the window_size register.
// ----------------------------------------------------------------------------
interface swm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [swm_pkg::CFG_BITS-1:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink   (input valid, input window_size, output ready);
endinterface

### src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sample shift row
// Holds one sample and whether it is still a candidate for the maximum.
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::swm_ctrl_t            ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          fresh,
	input  logic                          in_window,
	input  logic                          prev_alive,
	input  logic signed [SAMPLE_BITS-1:0] prev_value,
	output logic                          alive,
	output logic signed [SAMPLE_BITS-1:0] value
);
	import swm_pkg::*;

	logic                          alive_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic                          keep;

	// An older entry survives only if it is still inside the window and
	// strictly greater than the arriving sample.
	assign keep = fresh || (prev_alive && in_window && !ctrl.flush && (prev_value > sample));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (ctrl.shift) begin
			alive_q <= keep;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= prev_value;
		end
	end

	assign alive = alive_q;
	assign value = value_q;
endmodule

### src/swm_front.sv
// ----------------------------------------------------------------------------
// swm_front: selector of the queue front
// Finds the oldest live entry of the cell row in two registered stages and
// holds the result item for the output channel.
// ----------------------------------------------------------------------------
module swm_front #(
	parameter int LANES       = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      adv,
	input  swm_pkg::swm_stage_t                       stage,
	input  logic [LANES-1:0]                          alive,
	input  logic [LANES-1:0][SAMPLE_BITS-1:0]         values,
	output logic                                      out_valid,
	output logic signed [SAMPLE_BITS-1:0]             out_value,
	output logic                                      out_last
);
	import swm_pkg::*;

	localparam int GROUPS = (LANES + GROUP_LANES - 1) / GROUP_LANES;
	localparam int PAD    = GROUPS * GROUP_LANES;

	logic [PAD-1:0]                     alive_pad;
	logic [PAD-1:0][SAMPLE_BITS-1:0]    values_pad;
	logic [GROUPS-1:0]                  grp_found;
	logic [GROUPS-1:0][SAMPLE_BITS-1:0] grp_value;

	logic [GROUPS-1:0]                  found_s1;
	logic [GROUPS-1:0][SAMPLE_BITS-1:0] value_s1;
	swm_stage_t                         stage_s1;
	logic [SAMPLE_BITS-1:0]             sel_value;

	logic                               out_valid_q;
	logic                               out_last_q;
	logic [SAMPLE_BITS-1:0]             out_value_q;

	always_comb begin
		alive_pad  = '0;
		values_pad = '0;
		for (int i = 0; i < LANES; i++) begin
			alive_pad[i]  = alive[i];
			values_pad[i] = values[i];
		end
	end

	// Higher lane index means an older sample; the oldest live one is the front.
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_found[g] = 1'b0;
			grp_value[g] = values_pad[g*GROUP_LANES];
			for (int l = 0; l < GROUP_LANES; l++) begin
				if (alive_pad[g*GROUP_LANES + l]) begin
					grp_found[g] = 1'b1;
					grp_value[g] = values_pad[g*GROUP_LANES + l];
				end
			end
		end
	end

	always_comb begin
		sel_value = value_s1[0];
		for (int g = 0; g < GROUPS; g++) begin
			if (found_s1[g]) begin
				sel_value = value_s1[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1    <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			stage_s1    <= stage;
			out_valid_q <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_s1    <= grp_found;
			value_s1    <= grp_value;
			out_value_q <= sel_value;
			out_last_q  <= stage_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
endmodule

### src/sliding_window_maximum_top.sv
// Throughput: one sample item per cycle while the output does not stall; the row of cells
// updates in the cycle of acceptance. Pipeline from an accepted sample to its result item:
// cell row, group selector stage, output register; a stalled output holds the whole pipe.
// Reset: arst_n clears all candidates, the sample count and the output valid, and sets
// the window size to one. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// sliding_window_maximum_top: streaming sliding window maximum
// Monotonic queue kept as a row of cells over the most recent samples.
// ----------------------------------------------------------------------------
module sliding_window_maximum_top #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	swm_sample_if.sink   samples,
	swm_result_if.source results,
	swm_cfg_if.sink      cfg
);
	import swm_pkg::*;

	// KW holds a window length of up to MAX_WINDOW.
	localparam int KW  = $clog2(MAX_WINDOW + 1);
	localparam int KCW = (KW > CFG_BITS) ? KW : CFG_BITS;

	// Effective window length, already clamped into one to MAX_WINDOW.
	logic [KW-1:0]  k_q;
	logic [KCW-1:0] ws_ext;
	logic [KW-1:0]  k_new;

	// Samples seen in the current array, saturating at MAX_WINDOW.
	logic [KW-1:0] cnt_q;
	// The window has filled in the current array; sticky until the array ends.
	logic          full_q;
	// The previous item closed an array, so the next shift drops every candidate.
	logic          flush_q;

	logic       adv;
	logic       acc;
	logic       emit;
	logic       out_valid;
	swm_ctrl_t  ctrl;
	swm_stage_t stage_s0_q;

	logic [MAX_WINDOW-1:0]                  alive_w;
	logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] value_w;

	// Configuration: the clamp is applied once when the register is written.
	assign cfg.ready = 1'b1;

	always_comb begin
		ws_ext = KCW'(cfg.window_size);
		if (ws_ext == '0) begin
			k_new = KW'(1);
		end else if (ws_ext > KCW'(MAX_WINDOW)) begin
			k_new = KW'(MAX_WINDOW);
		end else begin
			k_new = ws_ext[KW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= KW'(1);
		end else if (cfg.valid) begin
			k_q <= k_new;
		end
	end

	// The whole pipe moves together whenever the output register is free or
	// being emptied, so a new sample can enter in the same cycle that a waiting result is taken.
	assign adv           = !out_valid || results.ready;
	assign samples.ready = adv;
	assign acc           = samples.valid && adv;

	// A result is due once the window has filled, or at the end of an array.
	assign emit = full_q || (cnt_q >= (k_q - KW'(1))) || samples.last_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			full_q     <= 1'b0;
			flush_q    <= 1'b0;
			stage_s0_q <= '0;
		end else begin
			if (adv) begin
				stage_s0_q.valid <= acc && emit;
				stage_s0_q.last  <= samples.last_sample;
			end
			if (acc) begin
				flush_q <= samples.last_sample;
				if (samples.last_sample) begin
					cnt_q  <= '0;
					full_q <= 1'b0;
				end else begin
					full_q <= emit;
					if (cnt_q != KW'(MAX_WINDOW)) begin
						cnt_q <= cnt_q + KW'(1);
					end
				end
			end
		end
	end

	assign ctrl.shift = acc;
	assign ctrl.flush = flush_q;

	// Cell 0 receives the arriving sample, which is always a candidate. Cell j
	// then holds the sample of age j; its entry stays live only while j is
	// below the window length and no newer sample has matched or beaten it.
	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		if (j == 0) begin : g_head
			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.sample    (samples.sample),
				.fresh     (1'b1),
				.in_window (1'b1),
				.prev_alive(1'b1),
				.prev_value(samples.sample),
				.alive     (alive_w[j]),
				.value     (value_w[j])
			);
		end else begin : g_body
			logic in_window;

			assign in_window = KW'(j) < k_q;

			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.sample    (samples.sample),
				.fresh     (1'b0),
				.in_window (in_window),
				.prev_alive(alive_w[j-1]),
				.prev_value(value_w[j-1]),
				.alive     (alive_w[j]),
				.value     (value_w[j])
			);
		end
	end

	// The oldest live cell is the queue front, which is the window maximum.
	swm_front #(
		.LANES      (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.stage    (stage_s0_q),
		.alive    (alive_w),
		.values   (value_w),
		.out_valid(out_valid),
		.out_value(results.window_max),
		.out_last (results.last_result)
	);

	assign results.valid = out_valid;
endmodule
